FILE: hw/rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the show-sync command deframer.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int MAX_NAME_LEN = 255;
  localparam int CNT_W        = $clog2(MAX_NAME_LEN + 1);
  localparam int SYNC_PAYLOAD = 8;
  localparam int FRAME_BYTES  = 4;

  localparam logic [7:0] CMD_SET_SEQUENCE_NAME = 8'd1;
  localparam logic [7:0] CMD_SET_MEDIA_NAME    = 8'd2;
  localparam logic [7:0] CMD_START_SEQUENCE    = 8'd3;
  localparam logic [7:0] CMD_START_MEDIA       = 8'd4;
  localparam logic [7:0] CMD_STOP_SEQUENCE     = 8'd5;
  localparam logic [7:0] CMD_STOP_MEDIA        = 8'd6;
  localparam logic [7:0] CMD_SYNC              = 8'd7;
  localparam logic [7:0] CMD_BLANK             = 8'd9;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEQ_NAME,
    PH_MEDIA_NAME,
    PH_SYNC
  } phase_t;

  typedef enum logic [3:0] {
    EV_SEQ_NAME,
    EV_MEDIA_NAME,
    EV_START_SEQ,
    EV_START_MEDIA,
    EV_STOP_SEQ,
    EV_STOP_MEDIA,
    EV_SYNC,
    EV_BLANK,
    EV_UNKNOWN,
    EV_OVERFLOW
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  name_byte;
    logic        name_last;
    logic [31:0] frame_number;
    logic [31:0] time_bits;
    logic        sync_sequence;
    logic        sync_media;
    logic        seq_active;
    logic        media_active;
  } result_t;

endpackage

FILE: hw/rtl/scd_ifs.sv
// ----------------------------------------------------------------------------
// scd channel interfaces
// Byte input channel and event output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  name_byte;
  logic        name_last;
  logic [31:0] frame_number;
  logic [31:0] time_bits;
  logic        sync_sequence;
  logic        sync_media;
  logic        seq_active;
  logic        media_active;

  modport source (output valid, output event_res, output name_byte, output name_last,
                  output frame_number, output time_bits, output sync_sequence,
                  output sync_media, output seq_active, output media_active,
                  input ready);
  modport sink   (input valid, input event_res, input name_byte, input name_last,
                  input frame_number, input time_bits, input sync_sequence,
                  input sync_media, input seq_active, input media_active,
                  output ready);
endinterface

FILE: hw/rtl/scd_parser.sv
// ----------------------------------------------------------------------------
// scd_parser
// Command state machine: one registered byte in, at most one event out.
// ----------------------------------------------------------------------------
module scd_parser
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output result_t    res
);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [31:0]        frame_shift, frame_shift_next;
  logic [31:0]        time_shift, time_shift_next;
  logic               seq_flag, seq_flag_next;
  logic               media_flag, media_flag_next;
  logic               name_done;
  logic               name_full;
  logic               sync_done;

  assign name_done = (byte_in == 8'd0);
  assign name_full = (byte_count >= CNT_W'(MAX_NAME_LEN));
  assign sync_done = (byte_count == CNT_W'(SYNC_PAYLOAD - 1));

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        unique case (byte_in)
          CMD_SET_SEQUENCE_NAME: phase_next = PH_SEQ_NAME;
          CMD_SET_MEDIA_NAME:    phase_next = PH_MEDIA_NAME;
          CMD_SYNC:              phase_next = PH_SYNC;
          default:               phase_next = PH_IDLE;
        endcase
      end
      PH_SEQ_NAME, PH_MEDIA_NAME: begin
        if (name_done || name_full) phase_next = PH_IDLE;
      end
      PH_SYNC: begin
        if (sync_done) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath and event
  always_comb begin
    byte_count_next  = byte_count;
    frame_shift_next = frame_shift;
    time_shift_next  = time_shift;
    seq_flag_next    = seq_flag;
    media_flag_next  = media_flag;
    res_valid        = 1'b0;
    res              = '0;
    res.event_res    = EV_UNKNOWN;
    unique case (phase)
      PH_IDLE: begin
        byte_count_next = '0;
        unique case (byte_in)
          CMD_SET_SEQUENCE_NAME, CMD_SET_MEDIA_NAME: ;
          CMD_SYNC: begin
            frame_shift_next = '0;
            time_shift_next  = '0;
          end
          CMD_START_SEQUENCE: begin
            res_valid     = seq_flag;
            res.event_res = EV_START_SEQ;
          end
          CMD_START_MEDIA: begin
            res_valid     = media_flag;
            res.event_res = EV_START_MEDIA;
          end
          CMD_STOP_SEQUENCE: begin
            res_valid     = seq_flag;
            res.event_res = EV_STOP_SEQ;
            seq_flag_next = 1'b0;
          end
          CMD_STOP_MEDIA: begin
            res_valid       = media_flag;
            res.event_res   = EV_STOP_MEDIA;
            media_flag_next = 1'b0;
          end
          CMD_BLANK: begin
            res_valid     = 1'b1;
            res.event_res = EV_BLANK;
          end
          default: begin
            // report unknown code as an unknown event, stay idle
            res_valid     = 1'b1;
            res.event_res = EV_UNKNOWN;
          end
        endcase
      end
      PH_SEQ_NAME, PH_MEDIA_NAME: begin
        res_valid     = 1'b1;
        res.event_res = (phase == PH_SEQ_NAME) ? EV_SEQ_NAME : EV_MEDIA_NAME;
        if (name_done) begin
          // empty name clears the flag, any other sets it
          if (phase == PH_SEQ_NAME) seq_flag_next = (byte_count != '0);
          else                      media_flag_next = (byte_count != '0);
          res.name_last   = 1'b1;
          byte_count_next = '0;
        end else if (name_full) begin
          res.event_res   = EV_OVERFLOW;
          byte_count_next = '0;
        end else begin
          res.name_byte   = byte_in;
          byte_count_next = byte_count + CNT_W'(1);
        end
      end
      PH_SYNC: begin
        if (byte_count < CNT_W'(FRAME_BYTES))
          frame_shift_next = {byte_in, frame_shift[31:8]};
        else
          time_shift_next = {byte_in, time_shift[31:8]};
        byte_count_next = sync_done ? '0 : byte_count + CNT_W'(1);
        res_valid         = sync_done && (seq_flag || media_flag);
        res.event_res     = EV_SYNC;
        res.frame_number  = frame_shift_next;
        res.time_bits     = time_shift_next;
        res.sync_sequence = seq_flag;
        res.sync_media    = media_flag;
      end
      default: ;
    endcase
    res.seq_active   = seq_flag_next;
    res.media_active = media_flag_next;
    res_valid        = res_valid && go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= '0;
      seq_flag   <= 1'b0;
      media_flag <= 1'b0;
    end else if (go) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      seq_flag   <= seq_flag_next;
      media_flag <= media_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      frame_shift <= frame_shift_next;
      time_shift  <= time_shift_next;
    end
  end

endmodule

FILE: hw/rtl/scd_out_buf.sv
// ----------------------------------------------------------------------------
// scd_out_buf
// Two-entry result buffer; full is registered so upstream ready stays local.
// ----------------------------------------------------------------------------
module scd_out_buf
  import scd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    valid,
  input  logic    ready,
  output result_t dout
);

  localparam int DEPTH = 2;

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'(DEPTH));
  assign pop   = valid && ready;
  assign dout  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) slot0 <= din;
      else               slot1 <= din;
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
        slot1 <= din;
      end
    end
  end

endmodule

FILE: hw/rtl/sync_command_deframer.sv
// Path: a byte accepted on the link is held in the input register and decoded
//   combinationally; any event is written into the result buffer and offered.
// Throughput: one byte per cycle while the result buffer is not full, set by
//   the single-pass decode between input register and two-entry result buffer.
// Reset (rst, synchronous): parser idle, both active flags clear, buffer empty.
// ----------------------------------------------------------------------------
// sync_command_deframer
// Splits received link bytes into show-sync command events.
// ----------------------------------------------------------------------------
module sync_command_deframer
  import scd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  scd_in_if.sink    link,
  scd_out_if.source events
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       buf_full;
  logic       go;
  logic       res_valid;
  result_t    res;
  result_t    dout;

  assign go         = in_valid && !buf_full;
  assign link.ready = !in_valid || !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (link.ready) begin
      in_valid <= link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link.valid && link.ready) in_byte <= link.rx_byte;
  end

  scd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .byte_in   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  scd_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .full  (buf_full),
    .valid (events.valid),
    .ready (events.ready),
    .dout  (dout)
  );

  assign events.event_res     = dout.event_res;
  assign events.name_byte     = dout.name_byte;
  assign events.name_last     = dout.name_last;
  assign events.frame_number  = dout.frame_number;
  assign events.time_bits     = dout.time_bits;
  assign events.sync_sequence = dout.sync_sequence;
  assign events.sync_media    = dout.sync_media;
  assign events.seq_active    = dout.seq_active;
  assign events.media_active  = dout.media_active;

endmodule

FILE: hw/rtl/scd_checker.sv
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks on the deframer event stream, bound to the top level.
// ----------------------------------------------------------------------------
module scd_checker
  import scd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  event_res,
  input logic [7:0]  name_byte,
  input logic        name_last,
  input logic        sync_sequence,
  input logic        sync_media,
  input logic        seq_active,
  input logic        media_active
);

  // a stalled event must stay offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_name_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && name_last |->
      name_byte == 8'd0 &&
      (event_res == EV_SEQ_NAME || event_res == EV_MEDIA_NAME))
    else $error("name end marker on wrong event");

  a_sync_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_SYNC |->
      (sync_sequence || sync_media) &&
      sync_sequence == seq_active && sync_media == media_active)
    else $error("sync event flags inconsistent");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_STOP_SEQ || event_res == EV_STOP_MEDIA) |->
      !(event_res == EV_STOP_SEQ && seq_active) &&
      !(event_res == EV_STOP_MEDIA && media_active))
    else $error("stop event left its flag set");

endmodule

bind sync_command_deframer scd_checker u_scd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (events.valid),
  .out_ready     (events.ready),
  .event_res     (events.event_res),
  .name_byte     (events.name_byte),
  .name_last     (events.name_last),
  .sync_sequence (events.sync_sequence),
  .sync_media    (events.sync_media),
  .seq_active    (events.seq_active),
  .media_active  (events.media_active)
);
